// File: rtl/blwd_pkg.sv
// Shared definitions for the bounded list block: request modes, status codes,
// default capacity and the request and response records.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blwd_pkg;

  // Default number of entries the list can hold
  localparam int unsigned CapacityDefault = 16;

  // Request modes
  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_REM_HEAD = 3'd1;
  localparam logic [2:0] MODE_REM_VAL  = 3'd2;
  localparam logic [2:0] MODE_CLEAR    = 3'd3;
  localparam logic [2:0] MODE_REPLACE  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] occupancy;
    logic       is_empty;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/bounded_list_with_delete.sv
// Top level of the bounded list block: input and output handshakes and the
// output register around the list sequencer. Depends on blwd_pkg, blwd_core.
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to CAPACITY signed 32-bit values, newest at the head.
// Each beat on the input carries a mode (insert at head, remove head, remove
// first match from the head, clear, replace all matches) and returns exactly
// one result beat with status, occupancy and an empty flag. Requests run one
// at a time. The entries sit in a single memory with one read and one write
// port, so each walk handles one entry per cycle. Insert, remove-head, clear,
// unused modes and any request on an empty list go straight to the result
// state; replace-all reads every entry once; remove-value reads from the head
// down to the first match and, for a match below the head, then moves each
// entry above it down by one, or reads the whole list when nothing matches.
// The next request is taken once the result has moved to the output register,
// even while that result stalls.
module bounded_list_with_delete #(
  parameter int unsigned CAPACITY = blwd_pkg::CapacityDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] new_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [4:0]       occupancy_o,
  output logic             is_empty_o
);

  blwd_pkg::req_t req;
  blwd_pkg::rsp_t rsp;
  blwd_pkg::rsp_t out_q;
  logic           busy;
  logic           rsp_valid;
  logic           out_valid_q;
  logic           out_free;
  logic           start;

  assign req.mode      = mode_i;
  assign req.value     = value_i;
  assign req.new_value = new_value_i;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  blwd_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .take_i      (out_free),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // Output beat valid: set on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= rsp_valid;
    end
  end

  // Output payload: load only into a free slot, hold while stalled
  always_ff @(posedge clk_i) begin
    if (out_free && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign occupancy_o = out_q.occupancy;
  assign is_empty_o  = out_q.is_empty;

endmodule

`default_nettype wire

// File: rtl/blwd_core.sv
// List sequencer and entry memory: runs one request at a time over a
// synchronous single-read, single-write memory. Depends on blwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blwd_core #(
  parameter int unsigned CAPACITY = blwd_pkg::CapacityDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire blwd_pkg::req_t req_i,
  input  wire logic          take_i,
  output logic               busy_o,
  output logic               rsp_valid_o,
  output blwd_pkg::rsp_t     rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SRCH = 5'b00010,
    ST_CMPT = 5'b00100,
    ST_RPLC = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  // Entries live in reverse order: the head sits at address count-1, so
  // insert and remove-head touch only one end.
  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] ra_q, ra_d;
  logic          iss_q, iss_d;
  logic          rv_q, rv_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   val_q, val_d;
  logic [31:0]   nval_q, nval_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] last_addr;
  logic          hit;

  assign last_addr = AW'(count_q - CW'(1));
  assign hit       = (rdata_q == val_q);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_q];
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_d     = rd_q;
    ra_d     = ra_q;
    iss_d    = iss_q;
    rv_d     = 1'b0;
    status_d = status_q;
    val_d    = val_q;
    nval_d   = nval_q;
    we       = 1'b0;
    waddr    = count_q[AW-1:0];
    wdata    = req_i.value;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d    = req_i.value;
          nval_d   = req_i.new_value;
          status_d = blwd_pkg::STAT_OK;
          iss_d    = 1'b1;
          state_d  = ST_RESP;
          case (req_i.mode)
            blwd_pkg::MODE_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = blwd_pkg::STAT_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            blwd_pkg::MODE_REM_HEAD: begin
              if (count_q == '0) begin
                status_d = blwd_pkg::STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            blwd_pkg::MODE_REM_VAL: begin
              if (count_q == '0) begin
                status_d = blwd_pkg::STAT_EMPTY;
              end else begin
                rd_d    = last_addr;
                state_d = ST_SRCH;
              end
            end
            blwd_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            blwd_pkg::MODE_REPLACE: begin
              if (count_q != '0) begin
                rd_d    = '0;
                state_d = ST_RPLC;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Walk from the head toward the tail, one read per cycle
      ST_SRCH: begin
        if (iss_q) begin
          rv_d = 1'b1;
          ra_d = rd_q;
          if (rd_q == '0) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q - AW'(1);
          end
        end
        if (rv_q) begin
          if (hit) begin
            if (ra_q == last_addr) begin
              count_d = count_q - CW'(1);
              state_d = ST_RESP;
            end else begin
              rd_d    = ra_q + AW'(1);
              iss_d   = 1'b1;
              rv_d    = 1'b0;
              state_d = ST_CMPT;
            end
          end else if (ra_q == '0) begin
            status_d = blwd_pkg::STAT_NOTFOUND;
            state_d  = ST_RESP;
          end
        end
      end

      // Close the gap: move each entry above the match down by one
      ST_CMPT: begin
        if (iss_q) begin
          rv_d = 1'b1;
          ra_d = rd_q;
          if (rd_q == last_addr) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q + AW'(1);
          end
        end
        if (rv_q) begin
          we    = 1'b1;
          waddr = ra_q - AW'(1);
          wdata = rdata_q;
          if (ra_q == last_addr) begin
            count_d = count_q - CW'(1);
            state_d = ST_RESP;
          end
        end
      end

      // Rewrite every matching entry in place
      ST_RPLC: begin
        if (iss_q) begin
          rv_d = 1'b1;
          ra_d = rd_q;
          if (rd_q == last_addr) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q + AW'(1);
          end
        end
        if (rv_q) begin
          if (hit) begin
            we    = 1'b1;
            waddr = ra_q;
            wdata = nval_q;
          end
          if (ra_q == last_addr) begin
            state_d = ST_RESP;
          end
        end
      end

      // Hold the result until the output side takes it
      ST_RESP: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      iss_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    ra_q     <= ra_d;
    status_q <= status_d;
    val_q    <= val_d;
    nval_q   <= nval_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign rsp_valid_o     = (state_q == ST_RESP);
  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = 5'(count_q);
  assign rsp_o.is_empty  = (count_q == '0);

endmodule

`default_nettype wire
